// ----- sv/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LIFO stack engine: command and status
// codes, the controller state type and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

  localparam int DATA_W          = 32;
  localparam int ENTRIES_W       = 9;
  localparam int CMD_W           = 3;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 256;

  typedef enum logic [CMD_W-1:0] {
    LSE_CMD_PUSH  = 3'd0,
    LSE_CMD_POP   = 3'd1,
    LSE_CMD_DUP   = 3'd2,
    LSE_CMD_SWAP  = 3'd3,
    LSE_CMD_CLEAR = 3'd4,
    LSE_CMD_PEEK  = 3'd5
  } lse_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    LSE_ST_OK    = 2'd0,
    LSE_ST_EMPTY = 2'd1,
    LSE_ST_FULL  = 2'd2,
    LSE_ST_FEW   = 2'd3
  } lse_status_t;

  typedef enum logic [1:0] {
    LSE_IDLE     = 2'd0,
    LSE_POP_FILL = 2'd1,
    LSE_SWAP_FIN = 2'd2
  } lse_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ENTRIES_W-1:0]     entries;
    lse_status_t              status;
    logic                     empty;
  } lse_result_t;

endpackage

`default_nettype wire

// ----- sv/lse_stack_mem.sv -----
// ----------------------------------------------------------------------------
// lse_stack_mem
// Word store below the cached top entry: one write port, one read port,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_stack_mem #(
  parameter int DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [$clog2(DEPTH)-1:0]            waddr,
  input  wire logic signed [lse_pkg::DATA_W-1:0]   wdata,
  input  wire logic                                re,
  input  wire logic [$clog2(DEPTH)-1:0]            raddr,
  output logic signed [lse_pkg::DATA_W-1:0]        rdata
);
  import lse_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/lse_ctrl.sv -----
// ----------------------------------------------------------------------------
// lse_ctrl
// Command sequencer: holds the count and the cached top word, drives the
// word store and produces one result record per command.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ctrl #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    accept,
  input  wire logic [lse_pkg::CMD_W-1:0]               cmd,
  input  wire logic signed [lse_pkg::DATA_W-1:0]       push_value,
  output logic                                         busy,
  output logic [$clog2(STACK_DEPTH+1)-1:0]             fill_level,
  output logic                                         mem_we,
  output logic [$clog2(STACK_DEPTH)-1:0]               mem_waddr,
  output logic signed [lse_pkg::DATA_W-1:0]            mem_wdata,
  output logic                                         mem_re,
  output logic [$clog2(STACK_DEPTH)-1:0]               mem_raddr,
  input  wire logic signed [lse_pkg::DATA_W-1:0]       mem_rdata,
  output logic                                         res_push,
  output lse_pkg::lse_result_t                         res
);
  import lse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  lse_state_t               state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;

  logic                     is_empty, at_full, two_plus;
  logic [AW-1:0]            fm1, fm2;
  logic signed [DATA_W-1:0] top_or_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LSE_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  assign is_empty    = (fill_r == '0);
  assign at_full     = (fill_r == CW'(STACK_DEPTH));
  assign two_plus    = (fill_r >= CW'(2));
  assign fm1         = AW'(fill_r - CW'(1));
  assign fm2         = AW'(fill_r - CW'(2));
  assign top_or_zero = is_empty ? '0 : top_r;
  assign busy        = (state_r != LSE_IDLE);
  assign fill_level  = fill_r;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    top_nxt     = top_r;
    mem_we      = 1'b0;
    mem_waddr   = fm1;
    mem_wdata   = top_r;
    mem_re      = 1'b0;
    mem_raddr   = fm2;
    res_push    = 1'b0;
    res.value   = top_or_zero;
    res.entries = ENTRIES_W'(fill_r);
    res.status  = LSE_ST_OK;
    res.empty   = is_empty;

    case (state_r)
      LSE_IDLE: begin
        if (accept) begin
          res_push = 1'b1;
          case (cmd)
            LSE_CMD_PUSH: begin
              if (at_full) begin
                res.status = LSE_ST_FULL;
              end else begin
                // old top moves down into the store
                mem_we    = !is_empty;
                top_nxt   = push_value;
                fill_nxt  = fill_r + CW'(1);
                res.value = push_value;
              end
            end
            LSE_CMD_POP: begin
              if (is_empty) begin
                res.status = LSE_ST_EMPTY;
              end else begin
                res.value = top_r;
                fill_nxt  = fill_r - CW'(1);
                if (two_plus) begin
                  mem_re    = 1'b1;
                  state_nxt = LSE_POP_FILL;
                end
              end
            end
            LSE_CMD_DUP: begin
              if (is_empty) begin
                res.status = LSE_ST_EMPTY;
              end else if (at_full) begin
                res.status = LSE_ST_FULL;
              end else begin
                mem_we    = 1'b1;
                fill_nxt  = fill_r + CW'(1);
                res.value = top_r;
              end
            end
            LSE_CMD_SWAP: begin
              if (!two_plus) begin
                res.status = LSE_ST_FEW;
              end else begin
                mem_re    = 1'b1;
                res_push  = 1'b0;
                state_nxt = LSE_SWAP_FIN;
              end
            end
            LSE_CMD_CLEAR: begin
              if (is_empty) begin
                res.status = LSE_ST_EMPTY;
              end
              fill_nxt  = '0;
              res.value = '0;
            end
            LSE_CMD_PEEK: begin
              if (is_empty) begin
                res.status = LSE_ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
          res.entries = ENTRIES_W'(fill_nxt);
          res.empty   = (fill_nxt == '0);
        end
      end
      LSE_POP_FILL: begin
        top_nxt   = mem_rdata;
        state_nxt = LSE_IDLE;
      end
      LSE_SWAP_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = fm2;
        mem_wdata = top_r;
        top_nxt   = mem_rdata;
        res_push  = 1'b1;
        res.value = mem_rdata;
        state_nxt = LSE_IDLE;
      end
      default: begin
        state_nxt = LSE_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/lse_outq.sv -----
// ----------------------------------------------------------------------------
// lse_outq
// Two-slot result queue: output register plus skid slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lse_pkg::lse_result_t push_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output lse_pkg::lse_result_t      out_data,
  output logic                      full
);
  import lse_pkg::*;

  logic [1:0]  cnt_r, cnt_nxt;
  lse_result_t slot0_r, slot1_r;
  logic        pop, wr0, wr1, shift;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  assign shift = pop && (cnt_r == 2'd2);
  assign wr0   = push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign wr1   = push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      slot0_r <= slot1_r;
    end else if (wr0) begin
      slot0_r <= push_data;
    end
    if (wr1) begin
      slot1_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lifo_stack_engine_unit.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_engine_unit
// Bounded LIFO stack of signed 32-bit words with push, pop, duplicate,
// swap, clear and peek; one result transaction per command transaction.
// ----------------------------------------------------------------------------
// The stack keeps its top word in a register and every entry below it in a
// synchronous memory of STACK_DEPTH words (one write and one read port, read
// data valid in the cycle after the address). Push, duplicate, clear, peek,
// failed commands and a pop from a one-entry stack finish in idle. A pop
// with two or more entries, and a successful swap, pass through POP_FILL or
// SWAP_FIN: the new top word has to come out of the memory read port before
// the next command can be taken. Results go into a two-slot output queue, so
// a new command is taken while an earlier result still waits on out_stall;
// in_stall rises while such a command is finishing or both queue slots are
// occupied. No clearing pass follows reset: only entries below the count are
// ever read. out_entries_held carries the count masked to 9 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_engine_unit #(
  parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // command transactions
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [lse_pkg::CMD_W-1:0]             in_cmd,
  input  wire logic signed [lse_pkg::DATA_W-1:0]     in_push_value,
  // result transactions
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [lse_pkg::DATA_W-1:0]          out_result_value,
  output logic [lse_pkg::ENTRIES_W-1:0]              out_entries_held,
  output logic [lse_pkg::STATUS_W-1:0]               out_status,
  output logic                                       out_now_empty
);
  import lse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic                     in_acc;
  logic                     busy;
  logic [CW-1:0]            fill_level;
  logic                     q_full;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata, mem_rdata;

  logic                     res_push;
  lse_result_t              res, out_res;

  // Taken only in idle with a free queue slot; a command that passes through
  // POP_FILL or SWAP_FIN then always finds room when its result is ready.
  assign in_stall = busy || q_full;
  assign in_acc   = in_valid && !in_stall;

  lse_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .cmd        (in_cmd),
    .push_value (in_push_value),
    .busy       (busy),
    .fill_level (fill_level),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_push   (res_push),
    .res        (res)
  );

  lse_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lse_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res),
    .full      (q_full)
  );

  assign out_result_value = out_res.value;
  assign out_entries_held = out_res.entries;
  assign out_status       = out_res.status;
  assign out_now_empty    = out_res.empty;

  // count never runs past the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_level <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  // a push below full grows the stack by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == LSE_CMD_PUSH) && (fill_level != CW'(STACK_DEPTH)))
    |=> (fill_level == $past(fill_level) + CW'(1)))
    else $error("push did not grow the stack");

  // a swap with two or more entries reports in the following cycle, count kept
  a_swap_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == LSE_CMD_SWAP) && (fill_level >= CW'(2)))
    |=> (res_push && busy && (fill_level == $past(fill_level))))
    else $error("swap result missing");

  // the controller never hands a result to a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !q_full)
    else $error("result queue overflow");

endmodule

`default_nettype wire
